// ----- rtl/text_terminal_char_buffer_defines.svh -----
// assertion macros for the text terminal character buffer
`ifndef TEXT_TERMINAL_CHAR_BUFFER_DEFINES_SVH
`define TEXT_TERMINAL_CHAR_BUFFER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TTCB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttcb assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define TTCB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttcb assertion failed");

`endif

// ----- rtl/ttcb_pkg.sv -----
// shared types and constants of the text terminal character buffer
package ttcb_pkg;

    // default geometry
    localparam int ROWS_DEF    = 12;
    localparam int COLUMNS_DEF = 12;

    // widths fixed by the word formats
    localparam int CELL_W  = 8;
    localparam int DIRTY_W = 12;
    localparam int POS_W   = 4;
    localparam int IDX_W   = 6;

    // operation codes
    localparam logic [2:0] OP_TERM   = 3'd0;
    localparam logic [2:0] OP_PUT    = 3'd1;
    localparam logic [2:0] OP_SCROLL = 3'd2;
    localparam logic [2:0] OP_CURSOR = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;
    localparam logic [2:0] OP_TAKE   = 3'd5;

    // scroll directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // character constants
    localparam logic [7:0] CHAR_BASE    = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

    // command word
    typedef struct packed {
        logic [2:0]       operation;
        logic [7:0]       char_code;
        logic [POS_W-1:0] cell_row;
        logic [POS_W-1:0] cell_column;
        logic [1:0]       scroll_dir;
    } cmd_word_t;

    // response word
    typedef struct packed {
        logic [7:0]         read_value;
        logic [DIRTY_W-1:0] dirty_mask;
        logic [POS_W-1:0]   cursor_row_out;
        logic [POS_W-1:0]   cursor_col_out;
    } rsp_word_t;

    // controls broadcast to every cell
    typedef struct packed {
        logic              shift_up;
        logic              shift_down;
        logic              shift_left;
        logic              shift_right;
        logic              write_en;
        logic [CELL_W-1:0] code;
    } cell_ctrl_t;

endpackage

// ----- rtl/ttcb_cell.sv -----
// one character cell: holds a code, loads it or takes a neighbor's code
module ttcb_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ttcb_pkg::cell_ctrl_t       ctrl,
    input  logic                       sel,
    input  logic [ttcb_pkg::CELL_W-1:0] from_above,
    input  logic [ttcb_pkg::CELL_W-1:0] from_below,
    input  logic [ttcb_pkg::CELL_W-1:0] from_left,
    input  logic [ttcb_pkg::CELL_W-1:0] from_right,
    output logic [ttcb_pkg::CELL_W-1:0] value,
    output logic [ttcb_pkg::CELL_W-1:0] rd_value,
    output logic                       changed
);

    logic [ttcb_pkg::CELL_W-1:0] code_reg;
    logic [ttcb_pkg::CELL_W-1:0] code_next;

    // write wins over a shift in the same cycle
    always_comb
    begin
        code_next = code_reg;
        if (ctrl.write_en && sel)
        begin
            code_next = ctrl.code;
        end
        else if (ctrl.shift_up)
        begin
            code_next = from_below;
        end
        else if (ctrl.shift_down)
        begin
            code_next = from_above;
        end
        else if (ctrl.shift_left)
        begin
            code_next = from_right;
        end
        else if (ctrl.shift_right)
        begin
            code_next = from_left;
        end
    end

    // cell storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= '0;
        end
        else
        begin
            code_reg <= code_next;
        end
    end

    // outputs to neighbors and to the row
    assign value    = code_reg;
    assign rd_value = sel ? code_reg : '0;
    assign changed  = ctrl.write_en && sel && (code_reg != ctrl.code);

endmodule

// ----- rtl/ttcb_row.sv -----
// one display row: a chain of cells linked left and right
module ttcb_row #(
    parameter int COLUMNS = ttcb_pkg::COLUMNS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  ttcb_pkg::cell_ctrl_t                     ctrl,
    input  logic                                     row_hit,
    input  logic [COLUMNS-1:0]                       col_sel,
    input  logic [COLUMNS-1:0][ttcb_pkg::CELL_W-1:0] above,
    input  logic [COLUMNS-1:0][ttcb_pkg::CELL_W-1:0] below,
    output logic [COLUMNS-1:0][ttcb_pkg::CELL_W-1:0] values,
    output logic [ttcb_pkg::CELL_W-1:0]              rd_value,
    output logic                                     changed
);

    logic [COLUMNS-1:0][ttcb_pkg::CELL_W-1:0] nb_left;
    logic [COLUMNS-1:0][ttcb_pkg::CELL_W-1:0] nb_right;
    logic [COLUMNS-1:0][ttcb_pkg::CELL_W-1:0] cell_rd;
    logic [COLUMNS-1:0]                       cell_chg;

    // cells with zero fill at both row ends
    for (genvar c = 0; c < COLUMNS; c++)
    begin : g_col
        if (c == 0)
        begin : g_first
            assign nb_left[c] = '0;
        end
        else
        begin : g_inner_l
            assign nb_left[c] = values[c-1];
        end
        if (c == COLUMNS - 1)
        begin : g_last
            assign nb_right[c] = '0;
        end
        else
        begin : g_inner_r
            assign nb_right[c] = values[c+1];
        end

        ttcb_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sel        (row_hit && col_sel[c]),
            .from_above (above[c]),
            .from_below (below[c]),
            .from_left  (nb_left[c]),
            .from_right (nb_right[c]),
            .value      (values[c]),
            .rd_value   (cell_rd[c]),
            .changed    (cell_chg[c])
        );
    end

    // combine the selected cell's code
    always_comb
    begin
        rd_value = '0;
        for (int c = 0; c < COLUMNS; c++)
        begin
            rd_value = rd_value | cell_rd[c];
        end
    end

    assign changed = |cell_chg;

endmodule

// ----- rtl/text_terminal_char_buffer.sv -----
// top level of the text terminal character buffer
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+-------------------------
//  cmd     | in        | cmd_valid/cmd_stall | ttcb_pkg::cmd_word_t
//  rsp     | out       | rsp_valid/rsp_stall | ttcb_pkg::rsp_word_t
//  cfg     | in        | cfg_we              | cfg_data (inverse_text)
//
// on the edge that accepts a command the cell array updates and the response
// register loads, so the response is valid in the cycle after. a scroll
// shifts every cell of the array on that same edge.
// reset clears cells, dirty mask, cursor and inverse flag at once.
// cmd_stall rises only while a response sits in the register and rsp_stall
// is high.
`include "text_terminal_char_buffer_defines.svh"

module text_terminal_char_buffer #(
    parameter int ROWS    = ttcb_pkg::ROWS_DEF,
    parameter int COLUMNS = ttcb_pkg::COLUMNS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  ttcb_pkg::cmd_word_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ttcb_pkg::rsp_word_t rsp,
    input  logic                cfg_we,
    input  logic                cfg_data
);

    localparam int RW = $clog2(ROWS + 1);
    localparam int CW = $clog2(COLUMNS + 1);
    localparam int MW = (ROWS > ttcb_pkg::DIRTY_W) ? ROWS : ttcb_pkg::DIRTY_W;
    localparam int IW = ttcb_pkg::IDX_W;
    localparam logic [ROWS-1:0] ROW_ALL = '1;

    logic                accept;
    logic                rsp_valid_reg;
    ttcb_pkg::rsp_word_t rsp_reg;
    ttcb_pkg::rsp_word_t rsp_next;
    logic                inverse_reg;
    logic [ROWS-1:0]     dirty_reg;
    logic [ROWS-1:0]     dirty_next;
    logic [ROWS-1:0]     dirty_now;
    logic [RW-1:0]       cursor_row_reg;
    logic [RW-1:0]       cursor_row_next;
    logic [CW-1:0]       cursor_col_reg;
    logic [CW-1:0]       cursor_col_next;

    ttcb_pkg::cell_ctrl_t ctrl;
    logic                 scroll_all;
    logic                 take;
    logic [IW-1:0]        tgt_row;
    logic [IW-1:0]        tgt_col;
    logic [ROWS-1:0]      row_sel;
    logic [COLUMNS-1:0]   col_sel;
    logic [ROWS-1:0]      row_chg;
    logic [7:0]           char_off;

    logic [ROWS-1:0][COLUMNS-1:0][ttcb_pkg::CELL_W-1:0] row_vals;
    logic [ROWS-1:0][COLUMNS-1:0][ttcb_pkg::CELL_W-1:0] nb_above;
    logic [ROWS-1:0][COLUMNS-1:0][ttcb_pkg::CELL_W-1:0] nb_below;
    logic [ROWS-1:0][ttcb_pkg::CELL_W-1:0]              row_rd;
    logic [ttcb_pkg::CELL_W-1:0]                        rd_all;

    // terminal write cursor path
    logic          row_lt;
    logic          col_full;
    logic [RW-1:0] row_inc;
    logic [RW-1:0] row1;
    logic [RW-1:0] row2;
    logic          row1_bottom;
    logic [CW-1:0] col1;
    logic          set_row_clamp;
    logic          set_row_bottom;
    logic          set_col_clamp;

    logic [IW-1:0] row_out_wide;
    logic [IW-1:0] col_out_wide;
    logic [MW-1:0] dirty_wide;

    // handshake
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // code stored for a written character
    assign char_off = cmd.char_code - ttcb_pkg::CHAR_BASE;

    // wrap and scroll decisions for a printable character
    assign row_lt      = cursor_row_reg < RW'(ROWS);
    assign col_full    = cursor_col_reg >= CW'(COLUMNS);
    assign row_inc     = cursor_row_reg + RW'(1);
    assign row1        = (col_full && row_lt) ? row_inc : cursor_row_reg;
    assign row1_bottom = row1 == RW'(ROWS);
    assign row2        = row1_bottom ? RW'(ROWS - 1) : row1;
    assign col1        = col_full ? '0 : cursor_col_reg;

    // set cursor clamping
    assign set_row_clamp  = IW'(cmd.cell_row) > IW'(ROWS);
    assign set_row_bottom = IW'(cmd.cell_row) >= IW'(ROWS);
    assign set_col_clamp  = IW'(cmd.cell_column) > IW'(COLUMNS);

    // operation decode
    always_comb
    begin
        ctrl            = '0;
        ctrl.code       = {inverse_reg, char_off[6:0]};
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        tgt_row         = IW'(cmd.cell_row);
        tgt_col         = IW'(cmd.cell_column);
        scroll_all      = 1'b0;
        take            = 1'b0;
        unique case (cmd.operation)
            ttcb_pkg::OP_TERM:
            begin
                if (cmd.char_code == ttcb_pkg::CHAR_NEWLINE)
                begin
                    cursor_col_next = '0;
                    if (row_lt)
                    begin
                        cursor_row_next = row_inc;
                    end
                    else
                    begin
                        ctrl.shift_up = 1'b1;
                        scroll_all    = 1'b1;
                    end
                end
                else if (cmd.char_code >= ttcb_pkg::CHAR_BASE)
                begin
                    ctrl.write_en   = 1'b1;
                    tgt_row         = IW'(row2);
                    tgt_col         = IW'(col1);
                    cursor_row_next = row2;
                    cursor_col_next = col1 + CW'(1);
                    if (row1_bottom)
                    begin
                        ctrl.shift_up = 1'b1;
                        scroll_all    = 1'b1;
                    end
                end
            end
            ttcb_pkg::OP_PUT:
            begin
                ctrl.write_en = 1'b1;
            end
            ttcb_pkg::OP_SCROLL:
            begin
                scroll_all = 1'b1;
                case (cmd.scroll_dir)
                    ttcb_pkg::DIR_UP:    ctrl.shift_up    = 1'b1;
                    ttcb_pkg::DIR_DOWN:  ctrl.shift_down  = 1'b1;
                    ttcb_pkg::DIR_LEFT:  ctrl.shift_left  = 1'b1;
                    default:             ctrl.shift_right = 1'b1;
                endcase
            end
            ttcb_pkg::OP_CURSOR:
            begin
                cursor_row_next = set_row_clamp ? RW'(ROWS) : RW'(cmd.cell_row);
                if (set_row_bottom)
                begin
                    cursor_col_next = '0;
                end
                else
                begin
                    cursor_col_next = set_col_clamp ? CW'(COLUMNS) : CW'(cmd.cell_column);
                end
            end
            ttcb_pkg::OP_TAKE:
            begin
                take = 1'b1;
            end
            default:
            begin
                // reads and unused codes leave the state alone
            end
        endcase
        if (!accept)
        begin
            ctrl.write_en    = 1'b0;
            ctrl.shift_up    = 1'b0;
            ctrl.shift_down  = 1'b0;
            ctrl.shift_left  = 1'b0;
            ctrl.shift_right = 1'b0;
        end
    end

    // one-hot target row and column
    for (genvar r = 0; r < ROWS; r++)
    begin : g_rsel
        assign row_sel[r] = tgt_row == IW'(r);
    end
    for (genvar c = 0; c < COLUMNS; c++)
    begin : g_csel
        assign col_sel[c] = tgt_col == IW'(c);
    end

    // cell array: rows chained up and down, zero fill at top and bottom
    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        if (r == 0)
        begin : g_top
            assign nb_above[r] = '0;
        end
        else
        begin : g_mid_a
            assign nb_above[r] = row_vals[r-1];
        end
        if (r == ROWS - 1)
        begin : g_bot
            assign nb_below[r] = '0;
        end
        else
        begin : g_mid_b
            assign nb_below[r] = row_vals[r+1];
        end

        ttcb_row #(
            .COLUMNS (COLUMNS)
        ) u_row (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .row_hit  (row_sel[r]),
            .col_sel  (col_sel),
            .above    (nb_above[r]),
            .below    (nb_below[r]),
            .values   (row_vals[r]),
            .rd_value (row_rd[r]),
            .changed  (row_chg[r])
        );
    end

    // selected cell across rows
    always_comb
    begin
        rd_all = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            rd_all = rd_all | row_rd[r];
        end
    end

    // dirty mask after the operation, cleared by take
    assign dirty_now  = scroll_all ? ROW_ALL : (dirty_reg | row_chg);
    assign dirty_next = take ? '0 : dirty_now;

    // response word
    assign row_out_wide = IW'(cursor_row_next);
    assign col_out_wide = IW'(cursor_col_next);
    assign dirty_wide   = MW'(dirty_now);

    always_comb
    begin
        rsp_next = '0;
        if ((cmd.operation == ttcb_pkg::OP_READ) && (|row_sel) && (|col_sel))
        begin
            rsp_next.read_value = {1'b0, rd_all[6:0]} + ttcb_pkg::CHAR_BASE;
        end
        rsp_next.dirty_mask     = dirty_wide[ttcb_pkg::DIRTY_W-1:0];
        rsp_next.cursor_row_out = row_out_wide[ttcb_pkg::POS_W-1:0];
        rsp_next.cursor_col_out = col_out_wide[ttcb_pkg::POS_W-1:0];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            inverse_reg    <= 1'b0;
            dirty_reg      <= '0;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                inverse_reg <= cfg_data;
            end
            if (accept)
            begin
                rsp_valid_reg  <= 1'b1;
                dirty_reg      <= dirty_next;
                cursor_row_reg <= cursor_row_next;
                cursor_col_reg <= cursor_col_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // checks
    `TTCB_ASSERT_NEXT(a_scroll_marks_all, accept && scroll_all, dirty_reg == ROW_ALL)
    `TTCB_ASSERT_NOW(a_row_in_range, 1'b1, cursor_row_reg <= RW'(ROWS))
    `TTCB_ASSERT_NOW(a_col_in_range, 1'b1, cursor_col_reg <= CW'(COLUMNS))
    `TTCB_ASSERT_NOW(a_bottom_col_zero, cursor_row_reg == RW'(ROWS), cursor_col_reg == '0)
    `TTCB_ASSERT_NEXT(a_take_clears, accept && take, dirty_reg == '0)

endmodule

// ----- tb/tb.sv -----
// testbench for the text terminal character buffer: random and directed words against a predictor
`timescale 1ns / 1ps

module tb;
    import ttcb_pkg::*;

    localparam int NROWS = ROWS_DEF;
    localparam int NCOLS = COLUMNS_DEF;
    localparam logic [DIRTY_W-1:0] ALL_ROWS = DIRTY_W'((1 << NROWS) - 1);
    localparam int BLOCK_WORDS = 95;
    localparam int BLOCKS_PER_PHASE = 6;
    localparam int LOG_LIMIT = 100;

    // shadow of the character buffer and the queue of responses still owed
    class char_buffer_board;
        logic [CELL_W-1:0]  cells [NROWS][NCOLS];
        logic [DIRTY_W-1:0] dirty;
        logic [POS_W-1:0]   cur_row;
        logic [POS_W-1:0]   cur_col;
        logic               inverse;
        rsp_word_t          owed_rsp [$];
        int                 errors;

        function new();
            for (int r = 0; r < NROWS; r++)
                for (int c = 0; c < NCOLS; c++)
                    cells[r][c] = '0;
            dirty   = '0;
            cur_row = '0;
            cur_col = '0;
            inverse = 1'b0;
            errors  = 0;
        endfunction

        function int owed_count();
            return owed_rsp.size();
        endfunction

        // store a character code, mark the row only on a real change
        function void store_char(int r, int c, logic [7:0] ch);
            logic [7:0] offset;
            logic [7:0] code;
            if (r >= NROWS || c >= NCOLS)
                return;
            offset = ch - CHAR_BASE;
            code   = {inverse, offset[6:0]};
            if (cells[r][c] !== code)
            begin
                cells[r][c] = code;
                dirty |= DIRTY_W'(1) << r;
            end
        endfunction

        // shift the whole array one step, vacated cells clear
        function void shift_cells(logic [1:0] dir);
            case (dir)
                DIR_UP:
                begin
                    for (int r = 0; r < NROWS; r++)
                        for (int c = 0; c < NCOLS; c++)
                            cells[r][c] = (r < NROWS - 1) ? cells[r+1][c] : '0;
                end
                DIR_DOWN:
                begin
                    for (int r = NROWS - 1; r >= 0; r--)
                        for (int c = 0; c < NCOLS; c++)
                            cells[r][c] = (r > 0) ? cells[r-1][c] : '0;
                end
                DIR_LEFT:
                begin
                    for (int r = 0; r < NROWS; r++)
                        for (int c = 0; c < NCOLS; c++)
                            cells[r][c] = (c < NCOLS - 1) ? cells[r][c+1] : '0;
                end
                default:
                begin
                    for (int r = 0; r < NROWS; r++)
                        for (int c = NCOLS - 1; c >= 0; c--)
                            cells[r][c] = (c > 0) ? cells[r][c-1] : '0;
                end
            endcase
            dirty = ALL_ROWS;
        endfunction

        // terminal style output with newline, wrap and scroll at the bottom
        function void terminal_char(logic [7:0] ch);
            if (ch == CHAR_NEWLINE)
            begin
                cur_col = '0;
                if (cur_row < NROWS)
                    cur_row = cur_row + 1'b1;
                else
                    shift_cells(DIR_UP);
            end
            else if (ch >= CHAR_BASE)
            begin
                if (cur_col >= NCOLS)
                begin
                    cur_col = '0;
                    if (cur_row < NROWS)
                        cur_row = cur_row + 1'b1;
                end
                if (cur_row >= NROWS)
                begin
                    shift_cells(DIR_UP);
                    cur_row = POS_W'(NROWS - 1);
                end
                store_char(cur_row, cur_col, ch);
                cur_col = cur_col + 1'b1;
            end
        endfunction

        // apply one accepted command word and queue the response it owes
        function void note_command(cmd_word_t w);
            rsp_word_t exp_rsp;
            logic      taken;
            exp_rsp = '0;
            taken   = 1'b0;
            case (w.operation)
                OP_TERM:   terminal_char(w.char_code);
                OP_PUT:    store_char(w.cell_row, w.cell_column, w.char_code);
                OP_SCROLL: shift_cells(w.scroll_dir);
                OP_CURSOR:
                begin
                    cur_row = (w.cell_row > NROWS) ? POS_W'(NROWS) : w.cell_row;
                    cur_col = (w.cell_column > NCOLS) ? POS_W'(NCOLS) : w.cell_column;
                    if (cur_row == NROWS)
                        cur_col = '0;
                end
                OP_READ:
                begin
                    if (w.cell_row < NROWS && w.cell_column < NCOLS)
                        exp_rsp.read_value = {1'b0, cells[w.cell_row][w.cell_column][6:0]}
                                             + CHAR_BASE;
                end
                OP_TAKE:   taken = 1'b1;
                default:   ;
            endcase
            exp_rsp.dirty_mask     = dirty;
            exp_rsp.cursor_row_out = cur_row;
            exp_rsp.cursor_col_out = cur_col;
            if (taken)
                dirty = '0;
            owed_rsp.push_back(exp_rsp);
        endfunction

        task report_mismatch(string what);
            errors++;
            // keep the log short when the block is badly broken
            if (errors <= LOG_LIMIT)
                $display("mismatch at %0t ns: %s", $time, what);
        endtask

        // compare one accepted response with the oldest owed one
        task check_response(rsp_word_t got);
            rsp_word_t exp_rsp;
            if (owed_rsp.size() == 0)
            begin
                report_mismatch("response with none owed");
                return;
            end
            exp_rsp = owed_rsp.pop_front();
            if (got.read_value !== exp_rsp.read_value)
                report_mismatch($sformatf("read_value got %h want %h",
                                          got.read_value, exp_rsp.read_value));
            if (got.dirty_mask !== exp_rsp.dirty_mask)
                report_mismatch($sformatf("dirty_mask got %h want %h",
                                          got.dirty_mask, exp_rsp.dirty_mask));
            if (got.cursor_row_out !== exp_rsp.cursor_row_out)
                report_mismatch($sformatf("cursor_row_out got %0d want %0d",
                                          got.cursor_row_out, exp_rsp.cursor_row_out));
            if (got.cursor_col_out !== exp_rsp.cursor_col_out)
                report_mismatch($sformatf("cursor_col_out got %0d want %0d",
                                          got.cursor_col_out, exp_rsp.cursor_col_out));
        endtask
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;
    logic      cfg_we    = 1'b0;
    logic      cfg_data  = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    char_buffer_board board = new();

    text_terminal_char_buffer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls at random
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_response(rsp);
    end

    // present one command word and hold it until accepted
    task automatic send_word(input cmd_word_t w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd       <= w;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        board.note_command(w);
    endtask

    // stop sending and wait for every owed response
    task automatic drain_responses();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (board.owed_count() != 0)
            @(posedge clk);
    endtask

    task automatic write_inverse(input logic v);
        @(negedge clk);
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(posedge clk);
        board.inverse = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic cmd_word_t make_word(logic [2:0] op, logic [7:0] ch,
                                            int r, int c, logic [1:0] dir);
        cmd_word_t w;
        w.operation   = op;
        w.char_code   = ch;
        w.cell_row    = POS_W'(r);
        w.cell_column = POS_W'(c);
        w.scroll_dir  = dir;
        return w;
    endfunction

    // random word, weighted toward text output and reads
    function automatic cmd_word_t random_word();
        cmd_word_t w;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 62)
            w.char_code = 8'($urandom_range(8'h20, 8'h7e));
        else if (pick < 72)
            w.char_code = CHAR_NEWLINE;
        else if (pick < 80)
            w.char_code = 8'($urandom_range(8'h1f));
        else
            w.char_code = 8'($urandom_range(8'h7f, 8'hff));
        w.cell_row    = ($urandom_range(99) < 85) ? 4'($urandom_range(NROWS))
                                                  : 4'($urandom_range(15));
        w.cell_column = ($urandom_range(99) < 85) ? 4'($urandom_range(NCOLS))
                                                  : 4'($urandom_range(15));
        w.scroll_dir  = 2'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 34)
            w.operation = OP_TERM;
        else if (pick < 48)
            w.operation = OP_PUT;
        else if (pick < 55)
            w.operation = OP_SCROLL;
        else if (pick < 66)
            w.operation = OP_CURSOR;
        else if (pick < 86)
            w.operation = OP_READ;
        else if (pick < 95)
            w.operation = OP_TAKE;
        else
            w.operation = 3'($urandom_range(6, 7));
        // park the cursor near the bottom often so scrolling gets exercised
        if (w.operation == OP_CURSOR && $urandom_range(1) == 1)
            w.cell_row = 4'($urandom_range(NROWS - 2, NROWS));
        return w;
    endfunction

    // mix of text lines and single random words
    task automatic run_random_block(input int count);
        cmd_word_t w;
        int        sent;
        int        run_len;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 30)
            begin
                run_len = $urandom_range(1, 16);
                for (int k = 0; k < run_len; k++)
                begin
                    w = random_word();
                    w.operation = OP_TERM;
                    w.char_code = 8'($urandom_range(8'h20, 8'h7e));
                    send_word(w);
                end
                w.char_code = CHAR_NEWLINE;
                send_word(w);
                sent += run_len + 1;
            end
            else
            begin
                send_word(random_word());
                sent++;
            end
        end
    endtask

    // run limit
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // main sequence
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_inverse(1'b0);

        // directed: reset state, out of range, no-change writes, bottom of screen
        send_word(make_word(OP_TAKE, 8'h00, 0, 0, DIR_UP));
        send_word(make_word(OP_READ, 8'h00, 0, 0, DIR_UP));
        send_word(make_word(OP_READ, 8'hff, 15, 15, DIR_RIGHT));
        send_word(make_word(OP_PUT, "A", 0, 0, DIR_UP));
        send_word(make_word(OP_TAKE, 8'h00, 0, 0, DIR_UP));
        send_word(make_word(OP_PUT, "A", 0, 0, DIR_UP));
        send_word(make_word(OP_TAKE, 8'h00, 0, 0, DIR_UP));
        send_word(make_word(OP_PUT, 8'hff, NROWS - 1, NCOLS - 1, DIR_UP));
        send_word(make_word(OP_PUT, "Z", NROWS, 0, DIR_UP));
        send_word(make_word(OP_PUT, "Z", 0, 15, DIR_UP));
        send_word(make_word(OP_READ, 8'h00, NROWS - 1, NCOLS - 1, DIR_UP));
        send_word(make_word(OP_CURSOR, 8'h00, 15, 15, DIR_UP));
        send_word(make_word(OP_TERM, "x", 0, 0, DIR_UP));
        send_word(make_word(OP_CURSOR, 8'h00, NROWS - 1, 15, DIR_UP));
        send_word(make_word(OP_TERM, "y", 0, 0, DIR_UP));
        send_word(make_word(OP_TERM, CHAR_NEWLINE, 0, 0, DIR_UP));
        send_word(make_word(OP_TERM, CHAR_NEWLINE, 0, 0, DIR_UP));
        send_word(make_word(OP_TERM, "!", 0, 0, DIR_UP));
        send_word(make_word(OP_TERM, 8'h01, 0, 0, DIR_UP));
        send_word(make_word(OP_TERM, 8'h80, 0, 0, DIR_UP));
        send_word(make_word(OP_SCROLL, 8'h00, 0, 0, DIR_DOWN));
        send_word(make_word(OP_SCROLL, 8'h00, 0, 0, DIR_LEFT));
        send_word(make_word(OP_SCROLL, 8'h00, 0, 0, DIR_RIGHT));
        send_word(make_word(3'd6, 8'h55, 5, 5, DIR_UP));
        send_word(make_word(3'd7, 8'haa, 10, 10, DIR_RIGHT));
        send_word(make_word(OP_READ, 8'h00, NROWS - 2, 1, DIR_UP));
        drain_responses();

        // inverse flag set: the read strips it, the dirty mask still sees it
        write_inverse(1'b1);
        send_word(make_word(OP_PUT, " ", 5, 5, DIR_UP));
        send_word(make_word(OP_READ, 8'h00, 5, 5, DIR_UP));
        send_word(make_word(OP_TAKE, 8'h00, 0, 0, DIR_UP));

        // random phases with different idling, config changes between blocks
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 22 : 0;
            for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++)
            begin
                run_random_block(BLOCK_WORDS);
                drain_responses();
                write_inverse(logic'(blk % 2));
            end
        end

        drain_responses();
        repeat (5) @(posedge clk);
        if (board.owed_count() != 0)
            board.report_mismatch("responses still owed at the end");
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ttcb_pkg.sv
rtl/ttcb_cell.sv
rtl/ttcb_row.sv
rtl/text_terminal_char_buffer.sv
tb/tb.sv
